// ===== sv/modbus_fc03_response_checker_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Modbus FC03 response checker - assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef MODBUS_FC03_RESPONSE_CHECKER_UNIT_MACROS_SVH
`define MODBUS_FC03_RESPONSE_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication.
`define MFC3_ASSERT_IMP(name, cond, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error("modbus fc03 checker: assertion failed");

// Next-cycle implication.
`define MFC3_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error("modbus fc03 checker: assertion failed");

`endif

// ===== sv/modfc3_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus FC03 response checker - package
// Constants, status codes, frame summary record and the CRC byte update.
// ----------------------------------------------------------------------------
package modfc3_pkg;

  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;
  localparam logic [7:0]  FuncReadHolding = 8'h03;
  localparam logic [7:0]  ExpectedCount   = 8'h04;
  localparam logic [3:0]  MinFrameLen     = 4'd9;

  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [2:0] {
    StOk    = 3'd0,
    StShort = 3'd1,
    StFunc  = 3'd2,
    StCount = 3'd3,
    StCrc   = 3'd4
  } status_e;

  // Summary of one finished frame, handed from front to back.
  typedef struct packed {
    logic        too_short;
    logic        func_ok;
    logic        count_ok;
    logic [15:0] crc_run;
    logic [15:0] crc_rx;
    logic [31:0] value;
  } frame_rec_t;

  // CRC-16/MODBUS update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/modbus_fc03_response_checker_unit.sv =====
// ----------------------------------------------------------------------------
// Modbus FC03 response checker - top level
// Checks received Modbus RTU read-holding-register responses byte by byte.
// ----------------------------------------------------------------------------
// Feed the received response one byte per beat on rx_byte_i, with frame_end_i
// high on the final byte. One byte is taken every clock while full is low:
// the CRC-16/MODBUS update (init 0xFFFF, reflected poly 0xA001) is an
// unrolled byte-wide step in the front end, run two bytes behind the newest
// byte so the two trailing CRC bytes are left out. Every final byte yields
// exactly one result on the output queue: status 0 ok, 1 shorter than nine
// bytes, 2 function code not 0x03, 3 byte count not 0x04, 4 CRC mismatch,
// checked in that order; reading_o holds the signed 32-bit value (bytes 5-6
// high word, bytes 3-4 low word) on success and zero otherwise. A frame's
// result passes through the summary queue and then the output register.
// Finished-frame summaries wait in a queue of QueueDepth entries ahead of the
// output register; full rises only when that queue is full, so input stalls
// only if results are not popped. Frame state returns to idle after each final
// byte, ready for the next frame.
// ----------------------------------------------------------------------------
module modbus_fc03_response_checker_unit #(
  parameter int unsigned QueueDepth = modfc3_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input queue side.
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_end_i,
  // Result queue side.
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status_o,
  output logic signed [31:0] reading_o
);

  modfc3_pkg::frame_rec_t front_rec, back_rec;
  logic                   rec_push;
  logic                   q_full, q_empty, q_pop;

  // Front end: frame tracking and CRC, one byte per beat.
  modfc3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .q_full_i    (q_full),
    .rx_byte_i   (rx_byte_i),
    .frame_end_i (frame_end_i),
    .rec_push_o  (rec_push),
    .rec_o       (front_rec)
  );

  // Decouple front and back so each can stall on its own.
  modfc3_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rec_push),
    .push_data_i (front_rec),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (back_rec),
    .empty_o     (q_empty)
  );

  // Back end: grade the frame and hold the result beat.
  modfc3_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rec_i     (back_rec),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .status_o  (status_o),
    .reading_o (reading_o)
  );

  // Hold off bytes only while no summary slot is free.
  assign full = q_full;

endmodule

// ===== sv/modfc3_front.sv =====
// ----------------------------------------------------------------------------
// Modbus FC03 response checker - front end
// Takes one byte per beat, tracks frame state and CRC, emits a frame summary.
// ----------------------------------------------------------------------------
module modfc3_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic                    q_full_i,
  input  logic [7:0]              rx_byte_i,
  input  logic                    frame_end_i,
  output logic                    rec_push_o,
  output modfc3_pkg::frame_rec_t  rec_o
);

  logic [3:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  trail0_q, trail0_d, trail1_q, trail1_d;
  logic [7:0]  pay_q [4];
  logic [7:0]  pay_d [4];
  logic        fm_q, fm_d, cm_q, cm_d;
  logic        accept;
  logic [15:0] crc_fed;
  logic        fm_new, cm_new;
  logic [7:0]  pay_new [4];

  assign accept = push_i && !q_full_i;

  always_comb begin
    crc_fed = (pos_q >= 4'd2) ? modfc3_pkg::crc_byte(crc_q, trail1_q) : crc_q;
    fm_new  = (pos_q == 4'd1) ? (rx_byte_i == modfc3_pkg::FuncReadHolding) : fm_q;
    cm_new  = (pos_q == 4'd2) ? (rx_byte_i == modfc3_pkg::ExpectedCount) : cm_q;
    for (int i = 0; i < 4; i++) begin
      pay_new[i] = (pos_q == 4'(i + 3)) ? rx_byte_i : pay_q[i];
    end

    pos_d    = pos_q;
    crc_d    = crc_q;
    trail0_d = trail0_q;
    trail1_d = trail1_q;
    fm_d     = fm_q;
    cm_d     = cm_q;
    pay_d    = pay_q;

    if (accept) begin
      if (frame_end_i) begin
        // Frame done: return every entry to its idle value.
        pos_d    = '0;
        crc_d    = modfc3_pkg::CrcInit;
        trail0_d = '0;
        trail1_d = '0;
        fm_d     = 1'b0;
        cm_d     = 1'b0;
        for (int i = 0; i < 4; i++) pay_d[i] = '0;
      end else begin
        pos_d    = (pos_q < modfc3_pkg::MinFrameLen) ? pos_q + 4'd1 : pos_q;
        crc_d    = crc_fed;
        trail0_d = rx_byte_i;
        trail1_d = trail0_q;
        fm_d     = fm_new;
        cm_d     = cm_new;
        pay_d    = pay_new;
      end
    end

    rec_push_o      = accept && frame_end_i;
    rec_o.too_short = (pos_q + 4'd1) < modfc3_pkg::MinFrameLen;
    rec_o.func_ok   = fm_new;
    rec_o.count_ok  = cm_new;
    rec_o.crc_run   = crc_fed;
    rec_o.crc_rx    = {rx_byte_i, trail0_q};
    rec_o.value     = {pay_new[2], pay_new[3], pay_new[0], pay_new[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= modfc3_pkg::CrcInit;
      trail0_q <= '0;
      trail1_q <= '0;
      fm_q     <= 1'b0;
      cm_q     <= 1'b0;
      for (int i = 0; i < 4; i++) pay_q[i] <= '0;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      trail0_q <= trail0_d;
      trail1_q <= trail1_d;
      fm_q     <= fm_d;
      cm_q     <= cm_d;
      pay_q    <= pay_d;
    end
  end

endmodule

// ===== sv/modfc3_queue.sv =====
// ----------------------------------------------------------------------------
// Modbus FC03 response checker - summary queue
// Small FIFO of frame summaries between front and back.
// ----------------------------------------------------------------------------
`include "modbus_fc03_response_checker_unit_macros.svh"

module modfc3_queue #(
  parameter int unsigned Depth = modfc3_pkg::QueueDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  modfc3_pkg::frame_rec_t push_data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output modfc3_pkg::frame_rec_t pop_data_o,
  output logic                   empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  modfc3_pkg::frame_rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en, rd_en;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign wr_en      = push_i && !full_o;
  assign rd_en      = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `MFC3_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(Depth))
  `MFC3_ASSERT_NEXT(a_push_fills, wr_en, !empty_o)
  `MFC3_ASSERT_NEXT(a_last_pop_drains, rd_en && !push_i && (cnt_q == CntW'(1)), empty_o)

endmodule

// ===== sv/modfc3_back.sv =====
// ----------------------------------------------------------------------------
// Modbus FC03 response checker - back end
// Grades a frame summary and holds the result until it is taken.
// ----------------------------------------------------------------------------
`include "modbus_fc03_response_checker_unit_macros.svh"

module modfc3_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  modfc3_pkg::frame_rec_t rec_i,
  input  logic                   q_empty_i,
  output logic                   q_pop_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic [2:0]             status_o,
  output logic signed [31:0]     reading_o
);

  logic                valid_q, valid_d;
  modfc3_pkg::status_e status_q, status_d;
  logic [31:0]         reading_q, reading_d;

  always_comb begin
    if (rec_i.too_short) begin
      status_d = modfc3_pkg::StShort;
    end else if (!rec_i.func_ok) begin
      status_d = modfc3_pkg::StFunc;
    end else if (!rec_i.count_ok) begin
      status_d = modfc3_pkg::StCount;
    end else if (rec_i.crc_rx != rec_i.crc_run) begin
      status_d = modfc3_pkg::StCrc;
    end else begin
      status_d = modfc3_pkg::StOk;
    end
    reading_d = (status_d == modfc3_pkg::StOk) ? rec_i.value : '0;

    // Load when the output slot is free or being taken this beat.
    q_pop_o = !q_empty_i && (!valid_q || pop_i);
    valid_d = q_pop_o ? 1'b1 : (pop_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      status_q  <= status_d;
      reading_q <= reading_d;
    end
  end

  assign empty_o   = !valid_q;
  assign status_o  = status_q;
  assign reading_o = signed'(reading_q);

  `MFC3_ASSERT_IMP(a_fail_reads_zero, valid_q && (status_q != modfc3_pkg::StOk), reading_q == '0)
  `MFC3_ASSERT_NEXT(a_load_fills, q_pop_o, valid_q)

endmodule
